// ===== src/bb3s_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3s_pkg: shared types and constants of the shifted-border box blur
// Channel widths, coordinate widths, register indexes and the result group
// record handed from the window stage to the result sequencer.
// ----------------------------------------------------------------------------
package bb3s_pkg;

  localparam int CH_W      = 8;    // bits per colour channel
  localparam int NUM_CH    = 3;    // red, green, blue
  localparam int PIX_W     = CH_W * NUM_CH;
  localparam int COLSUM_W  = 10;   // three channels added
  localparam int WINSUM_W  = 12;   // nine channels added
  localparam int OUT_COL_W = 10;
  localparam int OUT_ROW_W = 12;
  localparam int CFG_W_W   = 11;   // image_width register
  localparam int CFG_H_W   = 13;   // image_height register
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W = 1;

  // floor(s / 9) == (s * DIV9_MUL) >> DIV9_SHIFT for every window sum s.
  localparam int DIV9_MUL_W = 13;
  localparam int DIV9_SHIFT = 16;
  localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [CFG_W_W-1:0] IMAGE_WIDTH_RESET  = 11'd640;
  localparam logic [CFG_H_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;

  typedef logic [CH_W-1:0] chan_t;

  // One completed window and the output pixels that use it.
  typedef struct packed {
    logic [OUT_COL_W-1:0] col_base;
    logic                 two_cols;
    logic [OUT_ROW_W-1:0] row_base;
    logic                 two_rows;
    chan_t                red;
    chan_t                green;
    chan_t                blue;
  } group_t;

endpackage

// ===== src/bb3s_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3s_if: pixel and result channels of the box blur
// Valid/ready channels; an item moves on a rising edge with both high.
// ----------------------------------------------------------------------------
interface bb3s_pix_if;
  import bb3s_pkg::*;

  logic  valid;
  logic  ready;
  chan_t red_in;
  chan_t green_in;
  chan_t blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface bb3s_res_if;
  import bb3s_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUT_COL_W-1:0] out_column;
  logic [OUT_ROW_W-1:0] out_row;
  chan_t                red_out;
  chan_t                green_out;
  chan_t                blue_out;
  logic                 last_of_run;

  modport source (output valid, output out_column, output out_row, output red_out,
                  output green_out, output blue_out, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_column, input out_row, input red_out,
                  input green_out, input blue_out, input last_of_run,
                  output ready);
endinterface

// ===== src/box_blur_3x3_shifted_border.sv =====
`timescale 1ns / 1ps
// The first item caused by a pixel is offered once its group has moved from the window
// stage register into the result sequencer. Throughput: one pixel per cycle while each
// pixel causes at most one item and the result channel is ready; a pixel causing more
// items holds the sequencer until all are taken, slowing the border rows and columns.
// Reset (synchronous, active high) clears counters, column sums, pipeline valid flags
// and sets the frame size to 640 by 480; the line stores are not cleared.
// ----------------------------------------------------------------------------
// box_blur_3x3_shifted_border: 3x3 box average over an RGB raster stream
// Window sums come from two line stores and two column-sum registers; border
// windows are shifted inward and reused for the border output pixels.
// ----------------------------------------------------------------------------
module box_blur_3x3_shifted_border #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bb3s_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bb3s_pkg::CFG_DATA_W-1:0] cfg_data,
  bb3s_pix_if.sink                       pix,
  bb3s_res_if.source                     res
);
  import bb3s_pkg::*;

  // Counter widths follow the largest frame; the effective sizes may need one bit more
  // so that the largest size itself can be held.
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int WEW = $clog2(MAX_WIDTH + 1);
  localparam int HEW = $clog2(MAX_HEIGHT + 1);
  localparam int WCW = (WEW > CFG_W_W) ? WEW : CFG_W_W;
  localparam int HCW = (HEW > CFG_H_W) ? HEW : CFG_H_W;
  localparam int PROD_W = WINSUM_W + DIV9_MUL_W;

  // Configuration registers, to be written only while the block is idle; the block itself does not enforce this.
  logic [CFG_W_W-1:0] image_width;
  logic [CFG_H_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[CFG_W_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: the registers saturated to 4..MAX_WIDTH and 4..MAX_HEIGHT.
  logic [WCW-1:0] width_ext;
  logic [HCW-1:0] height_ext;
  logic [WEW-1:0] w_eff;
  logic [HEW-1:0] h_eff;

  assign width_ext  = WCW'(image_width);
  assign height_ext = HCW'(image_height);

  always_comb begin
    if (width_ext < WCW'(4)) begin
      w_eff = WEW'(4);
    end else if (width_ext > WCW'(MAX_WIDTH)) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(width_ext);
    end
    if (height_ext < HCW'(4)) begin
      h_eff = HEW'(4);
    end else if (height_ext > HCW'(MAX_HEIGHT)) begin
      h_eff = HEW'(MAX_HEIGHT);
    end else begin
      h_eff = HEW'(height_ext);
    end
  end

  // Handshake. The window stage finishes an item once its result group, if any,
  // can move into the sequencer; a new pixel enters as the stage empties.
  logic   accept;
  logic   s1_valid;
  logic   s1_done;
  logic   emit_free;
  logic   emit_load;

  logic   s1_has;
  group_t s1_group;

  assign s1_done   = s1_valid && (!s1_has || emit_free);
  assign pix.ready = !s1_valid || s1_done;
  assign accept    = pix.valid && pix.ready;
  assign emit_load = s1_valid && s1_has && emit_free;

  // Raster position of the next pixel.
  logic [XW-1:0] column_counter;
  logic [YW-1:0] row_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
    end else if (accept) begin
      if (WEW'(column_counter) >= w_eff - WEW'(1)) begin
        column_counter <= '0;
        if (HEW'(row_counter) >= h_eff - HEW'(1)) begin
          row_counter <= '0;
        end else begin
          row_counter <= row_counter + YW'(1);
        end
      end else begin
        column_counter <= column_counter + XW'(1);
      end
    end
  end

  // Decide at acceptance which output pixels the completed window serves. A window
  // at an edge of the frame also serves the edge pixel on that side.
  logic   has_result;
  logic   first_col;
  logic   last_col;
  logic   first_row;
  logic   last_row;
  group_t new_group;

  always_comb begin
    has_result = (column_counter >= XW'(2)) && (WEW'(column_counter) < w_eff) &&
                 (row_counter >= YW'(2)) && (HEW'(row_counter) < h_eff);
    first_col  = (column_counter == XW'(2));
    last_col   = (WEW'(column_counter) == w_eff - WEW'(1));
    first_row  = (row_counter == YW'(2));
    last_row   = (HEW'(row_counter) == h_eff - HEW'(1));
    new_group          = '0;
    new_group.col_base = first_col ? '0 : OUT_COL_W'(column_counter - XW'(1));
    new_group.two_cols = first_col || last_col;
    new_group.row_base = first_row ? '0 : OUT_ROW_W'(row_counter - YW'(1));
    new_group.two_rows = first_row || last_row;
  end

  // Window stage registers. The channel values of the group are filled in later.
  logic [NUM_CH-1:0][CH_W-1:0] s1_pix;
  logic [XW-1:0]               s1_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= {pix.red_in, pix.green_in, pix.blue_in};
      s1_x     <= column_counter;
      s1_has   <= has_result;
      s1_group <= new_group;
    end
  end

  // Both line stores share one memory: each word holds the pixel two rows up in
  // its upper half and the pixel one row up in its lower half. Reading at the
  // column on acceptance and writing it back as the window stage finishes never
  // collide, since consecutive pixels always sit in different columns.
  logic                  rd_en;
  logic                  wr_en;
  logic [2*PIX_W-1:0]    rd_word;
  logic [2*PIX_W-1:0]    wr_word;
  logic [NUM_CH-1:0][CH_W-1:0] two_back;
  logic [NUM_CH-1:0][CH_W-1:0] one_back;

  assign rd_en    = accept && (int'(column_counter) < MAX_WIDTH);
  assign wr_en    = s1_done && (int'(s1_x) < MAX_WIDTH);
  assign two_back = rd_word[2*PIX_W-1:PIX_W];
  assign one_back = rd_word[PIX_W-1:0];
  assign wr_word  = {one_back, s1_pix};

  bb3s_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2*PIX_W)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_x),
    .wr_data (wr_word),
    .rd_en   (rd_en),
    .rd_addr (column_counter),
    .rd_data (rd_word)
  );

  // Three-row column sum of the current column, then the window sum over this and
  // the two previous columns, divided by nine through a reciprocal multiply that
  // is exact over the whole range of window sums.
  logic [NUM_CH-1:0][COLSUM_W-1:0] col_sum;
  logic [NUM_CH-1:0][COLSUM_W-1:0] prior_sum0;
  logic [NUM_CH-1:0][COLSUM_W-1:0] prior_sum1;
  logic [NUM_CH-1:0][WINSUM_W-1:0] win_sum;
  logic [NUM_CH-1:0][PROD_W-1:0]   prod;
  logic [NUM_CH-1:0][CH_W-1:0]     avg;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      col_sum[k] = COLSUM_W'(two_back[k]) + COLSUM_W'(one_back[k]) +
                   COLSUM_W'(s1_pix[k]);
      win_sum[k] = WINSUM_W'(prior_sum0[k]) + WINSUM_W'(prior_sum1[k]) +
                   WINSUM_W'(col_sum[k]);
      prod[k]    = PROD_W'(win_sum[k]) * PROD_W'(DIV9_MUL);
      avg[k]     = prod[k][DIV9_SHIFT +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_sum0 <= '0;
      prior_sum1 <= '0;
    end else if (s1_done) begin
      prior_sum1 <= prior_sum0;
      prior_sum0 <= col_sum;
    end
  end

  group_t emit_group;

  always_comb begin
    emit_group       = s1_group;
    emit_group.red   = avg[2];
    emit_group.green = avg[1];
    emit_group.blue  = avg[0];
  end

  // The sequencer is the output register: its items go one a cycle while res.ready is high.
  bb3s_emit u_emit (
    .clk   (clk),
    .rst   (rst),
    .load  (emit_load),
    .group (emit_group),
    .free  (emit_free),
    .res   (res)
  );

endmodule

// ===== src/bb3s_line_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3s_line_ram: line store memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bb3s_line_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 48
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/bb3s_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3s_emit: result sequencer
// Holds one window's result group and hands out its one to four items,
// columns first within a row, then the next row.
// ----------------------------------------------------------------------------
module bb3s_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  bb3s_pkg::group_t group,
  output logic            free,
  bb3s_res_if.source      res
);
  import bb3s_pkg::*;

  logic   g_valid;
  group_t g;
  logic   gi;
  logic   gj;
  logic   last;
  logic   take;

  assign last = (gi == g.two_rows) && (gj == g.two_cols);
  assign take = g_valid && res.ready;
  assign free = !g_valid || (res.ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
      gi      <= 1'b0;
      gj      <= 1'b0;
    end else if (load) begin
      g_valid <= 1'b1;
      g       <= group;
      gi      <= 1'b0;
      gj      <= 1'b0;
    end else if (take) begin
      if (last) begin
        g_valid <= 1'b0;
      end else if (gj != g.two_cols) begin
        gj <= 1'b1;
      end else begin
        gj <= 1'b0;
        gi <= 1'b1;
      end
    end
  end

  assign res.valid       = g_valid;
  assign res.out_column  = g.col_base + OUT_COL_W'(gj);
  assign res.out_row     = g.row_base + OUT_ROW_W'(gi);
  assign res.red_out     = g.red;
  assign res.green_out   = g.green;
  assign res.blue_out    = g.blue;
  assign res.last_of_run = last;

endmodule

// ===== src/bb3s_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3s_checker: port-level checks of the box blur
// Watches the pixel and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module bb3s_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [bb3s_pkg::OUT_COL_W-1:0] out_column,
  input logic [bb3s_pkg::OUT_ROW_W-1:0] out_row,
  input logic [bb3s_pkg::CH_W-1:0]      red_out,
  input logic [bb3s_pkg::CH_W-1:0]      green_out,
  input logic [bb3s_pkg::CH_W-1:0]      blue_out,
  input logic                           last_of_run
);
  import bb3s_pkg::*;

  // After reset the block is empty and ready for a pixel.
  a_reset_empty: assert property (@(posedge clk) rst |=> (!out_valid && in_ready))
    else $error("block not empty after reset");

  // A stalled item holds still.
  a_hold: assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_ready) |=>
      (out_valid && $stable(out_column) && $stable(out_row) && $stable(red_out) &&
       $stable(green_out) && $stable(blue_out) && $stable(last_of_run)))
    else $error("stalled result changed");

  // A group is never cut short: after an item that is not the last, another follows.
  a_group_cont: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_ready && !last_of_run) |=> out_valid)
    else $error("result group broken off");

  // All items of one group carry the same average.
  a_group_same: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_ready && !last_of_run) |=>
      (red_out == $past(red_out) && green_out == $past(green_out) &&
       blue_out == $past(blue_out)))
    else $error("averages differ within a group");

endmodule

bind box_blur_3x3_shifted_border bb3s_checker u_bb3s_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (pix.ready),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .out_column  (res.out_column),
  .out_row     (res.out_row),
  .red_out     (res.red_out),
  .green_out   (res.green_out),
  .blue_out    (res.blue_out),
  .last_of_run (res.last_of_run)
);
